>>> rtl/fcc_pkg.sv
package fcc_pkg;

  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned RATE_W  = 6;
  localparam int unsigned ALARM_W = 2;
  localparam int unsigned REG_IDX_W = 4;

  // PWM duty levels.
  localparam logic [LEVEL_W-1:0] PWM_LOW = 8'd64;
  localparam logic [LEVEL_W-1:0] PWM_MID = 8'd128;
  localparam logic [LEVEL_W-1:0] PWM_TOP = 8'd255;

  // Alarm request codes.
  localparam logic [ALARM_W-1:0] ALARM_NONE     = 2'd0;
  localparam logic [ALARM_W-1:0] ALARM_OVERTEMP = 2'd1;
  localparam logic [ALARM_W-1:0] ALARM_FANFAIL  = 2'd2;

  // Item kinds.
  localparam logic FUNC_PULSE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_OVERTEMP = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_FAN_ON   = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_FAN_OFF  = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOW_LVL  = 4'd3;
  localparam logic [REG_IDX_W-1:0] REG_MID_LVL  = 4'd4;
  localparam logic [REG_IDX_W-1:0] REG_TOP_LVL  = 4'd5;
  localparam logic [REG_IDX_W-1:0] REG_AUTO     = 4'd6;
  localparam logic [REG_IDX_W-1:0] REG_RATE     = 4'd7;

  // Register reset values.
  localparam logic [TEMP_W-1:0] RST_OVERTEMP = 8'd80;
  localparam logic [TEMP_W-1:0] RST_FAN_ON   = 8'd40;
  localparam logic [TEMP_W-1:0] RST_FAN_OFF  = 8'd35;
  localparam logic [TEMP_W-1:0] RST_LOW_LVL  = 8'd40;
  localparam logic [TEMP_W-1:0] RST_MID_LVL  = 8'd55;
  localparam logic [TEMP_W-1:0] RST_TOP_LVL  = 8'd70;
  localparam logic              RST_AUTO     = 1'b1;
  localparam logic [RATE_W-1:0] RST_RATE     = 6'd30;

  typedef struct packed {
    logic [TEMP_W-1:0] alarm_temp;
    logic [TEMP_W-1:0] start_temp;
    logic [TEMP_W-1:0] stop_temp;
    logic [TEMP_W-1:0] low_level_threshold;
    logic [TEMP_W-1:0] mid_level_threshold;
    logic [TEMP_W-1:0] top_level_threshold;
    logic              auto_mode;
    logic [RATE_W-1:0] rpm_per_pulse;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [TEMP_W-1:0] temperature;
    logic              load_on;
    logic              alarm_active;
  } item_t;

  typedef struct packed {
    logic               fan_enable;
    logic [LEVEL_W-1:0] pwm_level;
    logic [RPM_W-1:0]   fan_rpm;
    logic [ALARM_W-1:0] alarm_request;
  } result_t;

endpackage

>>> rtl/fan_cooling_controller.sv
// Fan cooling controller.
// Input channel (in_valid/in_stall): each word is either a tach pulse (in_func = 0),
// which bumps a saturating pulse counter, or a cooling tick (in_func = 1) carrying
// temperature, load state and the external alarm flag. Every input word yields
// exactly one result word on the output channel (out_valid/out_stall) giving the
// fan enable, PWM level, last measured rpm and any alarm request.
// Thresholds, auto mode and rpm per pulse are set through the cfg_ write channel,
// which is always ready; writes should only be made while the block is idle.
// An accepted word passes through the input register, then the compare and 16x6
// multiply logic feeding the output register. Throughput is one word per cycle
// unless the receiver stalls; the input register and output register form a
// two-deep pipeline, so a new word is taken while a result is still waiting.
// When the receiver stalls, the result holds and the input register fills; in_stall
// rises only once both stages are occupied.
// Synchronous reset clears the pipeline, the fan state, counters and level, and
// loads the configuration registers with their default values.
module fan_cooling_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [fcc_pkg::TEMP_W-1:0]    in_temperature,
  input  logic                          in_load_on,
  input  logic                          in_alarm_active,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_fan_enable,
  output logic [fcc_pkg::LEVEL_W-1:0]   out_pwm_level,
  output logic [fcc_pkg::RPM_W-1:0]     out_fan_rpm,
  output logic [fcc_pkg::ALARM_W-1:0]   out_alarm_request,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fcc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [fcc_pkg::TEMP_W-1:0]    cfg_data
);

  fcc_pkg::cfg_t    cfg;
  fcc_pkg::item_t   item_r;
  fcc_pkg::result_t result, result_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_take;
  logic             s1_go;
  logic             s1_fire;

  assign cfg_ready = 1'b1;

  fcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The first stage moves on whenever the output register is empty or being taken.
  assign s1_go    = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.func         <= in_func;
      item_r.temperature  <= in_temperature;
      item_r.load_on      <= in_load_on;
      item_r.alarm_active <= in_alarm_active;
    end
    if (s1_fire) begin
      result_r <= result;
    end
  end

  fcc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (s1_fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  assign out_valid         = out_valid_r;
  assign out_fan_enable    = result_r.fan_enable;
  assign out_pwm_level     = result_r.pwm_level;
  assign out_fan_rpm       = result_r.fan_rpm;
  assign out_alarm_request = result_r.alarm_request;

  a_alarm_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_alarm_request == fcc_pkg::ALARM_NONE
                     || out_alarm_request == fcc_pkg::ALARM_OVERTEMP
                     || out_alarm_request == fcc_pkg::ALARM_FANFAIL))
    else $error("alarm request carries an unused code");

  a_fanfail_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_alarm_request == fcc_pkg::ALARM_FANFAIL)
      |-> (out_fan_enable && out_fan_rpm == '0))
    else $error("fan failure reported without a running fan at zero rpm");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while the pipeline has room");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result register not filled after the first stage moved on");

endmodule

>>> rtl/fcc_cfg_regs.sv
module fcc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [fcc_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [fcc_pkg::TEMP_W-1:0]    wr_data,
  output fcc_pkg::cfg_t                 cfg
);

  fcc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        fcc_pkg::REG_OVERTEMP: cfg_nxt.alarm_temp          = wr_data;
        fcc_pkg::REG_FAN_ON:   cfg_nxt.start_temp          = wr_data;
        fcc_pkg::REG_FAN_OFF:  cfg_nxt.stop_temp           = wr_data;
        fcc_pkg::REG_LOW_LVL:  cfg_nxt.low_level_threshold = wr_data;
        fcc_pkg::REG_MID_LVL:  cfg_nxt.mid_level_threshold = wr_data;
        fcc_pkg::REG_TOP_LVL:  cfg_nxt.top_level_threshold = wr_data;
        fcc_pkg::REG_AUTO:     cfg_nxt.auto_mode           = wr_data[0];
        fcc_pkg::REG_RATE:     cfg_nxt.rpm_per_pulse       = wr_data[fcc_pkg::RATE_W-1:0];
        default: ; // Writes to unused indexes are dropped.
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_temp          <= fcc_pkg::RST_OVERTEMP;
      cfg_r.start_temp          <= fcc_pkg::RST_FAN_ON;
      cfg_r.stop_temp           <= fcc_pkg::RST_FAN_OFF;
      cfg_r.low_level_threshold <= fcc_pkg::RST_LOW_LVL;
      cfg_r.mid_level_threshold <= fcc_pkg::RST_MID_LVL;
      cfg_r.top_level_threshold <= fcc_pkg::RST_TOP_LVL;
      cfg_r.auto_mode           <= fcc_pkg::RST_AUTO;
      cfg_r.rpm_per_pulse       <= fcc_pkg::RST_RATE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/fcc_core.sv
module fcc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  fcc_pkg::item_t   item,
  input  fcc_pkg::cfg_t    cfg,
  output fcc_pkg::result_t result
);

  localparam int unsigned PROD_W = fcc_pkg::COUNT_W + fcc_pkg::RATE_W;

  logic                          fan_running_r, fan_running_nxt;
  logic [fcc_pkg::COUNT_W-1:0]   pulse_count_r, pulse_count_nxt;
  logic [fcc_pkg::RPM_W-1:0]     speed_rpm_r, speed_rpm_nxt;
  logic [fcc_pkg::LEVEL_W-1:0]   duty_level_r, duty_level_nxt;
  logic [fcc_pkg::ALARM_W-1:0]   alarm;
  logic [PROD_W-1:0]             prod;
  logic [fcc_pkg::RPM_W-1:0]     speed_sat;
  logic                          overtemp;
  logic                          stop_fan;

  assign prod = {{fcc_pkg::RATE_W{1'b0}}, pulse_count_r}
              * {{fcc_pkg::COUNT_W{1'b0}}, cfg.rpm_per_pulse};
  assign speed_sat = (prod[PROD_W-1:fcc_pkg::RPM_W] != '0) ? '1
                                                            : prod[fcc_pkg::RPM_W-1:0];

  assign overtemp = item.load_on && (item.temperature >= cfg.alarm_temp)
                    && !item.alarm_active;
  assign stop_fan = !item.load_on && (item.temperature <= cfg.stop_temp)
                    && cfg.auto_mode;

  always_comb begin
    fan_running_nxt = fan_running_r;
    pulse_count_nxt = pulse_count_r;
    speed_rpm_nxt   = speed_rpm_r;
    duty_level_nxt  = duty_level_r;
    alarm           = fcc_pkg::ALARM_NONE;

    if (item.func == fcc_pkg::FUNC_PULSE) begin
      if (pulse_count_r != '1) begin
        pulse_count_nxt = pulse_count_r + 1'b1;
      end
    end else begin
      if (overtemp) begin
        alarm = fcc_pkg::ALARM_OVERTEMP;
      end else if (fan_running_r) begin
        if (stop_fan) begin
          fan_running_nxt = 1'b0;
        end else begin
          speed_rpm_nxt   = speed_sat;
          pulse_count_nxt = '0;
          if ((speed_sat == '0) && !item.alarm_active) begin
            alarm = fcc_pkg::ALARM_FANFAIL;
          end
        end
      end else if (item.load_on && (item.temperature >= cfg.start_temp)) begin
        fan_running_nxt = 1'b1;
      end

      // A fan that has just stopped has fan_running_nxt low, so it keeps its level.
      if (fan_running_nxt) begin
        if (item.temperature >= cfg.top_level_threshold) begin
          duty_level_nxt = fcc_pkg::PWM_TOP;
        end else if (item.temperature >= cfg.mid_level_threshold) begin
          duty_level_nxt = fcc_pkg::PWM_MID;
        end else if (item.temperature >= cfg.low_level_threshold) begin
          duty_level_nxt = fcc_pkg::PWM_LOW;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_running_r <= 1'b0;
      pulse_count_r <= '0;
      speed_rpm_r   <= '0;
      duty_level_r  <= '0;
    end else if (en) begin
      fan_running_r <= fan_running_nxt;
      pulse_count_r <= pulse_count_nxt;
      speed_rpm_r   <= speed_rpm_nxt;
      duty_level_r  <= duty_level_nxt;
    end
  end

  assign result.fan_enable    = fan_running_nxt;
  assign result.pwm_level     = duty_level_nxt;
  assign result.fan_rpm       = speed_rpm_nxt;
  assign result.alarm_request = alarm;

endmodule
